FILE: rtl/cufp_pkg.sv
package cufp_pkg;

	// sync pattern and frame positions
	localparam logic [7:0] SYNC_A = 8'd30;
	localparam logic [7:0] SYNC_B = 8'd29;
	localparam logic [7:0] SYNC_C = 8'd28;
	localparam logic [6:0] POS_SYNC_A  = 7'd0;
	localparam logic [6:0] POS_SYNC_B  = 7'd1;
	localparam logic [6:0] POS_SYNC_C  = 7'd2;
	localparam logic [6:0] POS_COMMAND = 7'd3;
	localparam logic [6:0] POS_PAYLOAD = 7'd4;

	// frame lengths
	localparam int HID_PAYLOAD_BYTES_DEF    = 32;
	localparam int WEBUSB_PAYLOAD_BYTES_DEF = 64;
	localparam int BATTERY_PAYLOAD_BYTES    = 4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_HID_CODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEBUSB_CODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_CODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_EN     = 3'd4;

	typedef enum logic [1:0] {
		EV_LOG     = 2'd0,
		EV_UNKNOWN = 2'd1,
		EV_PAYLOAD = 2'd2
	} ev_t;

	typedef enum logic [1:0] {
		KIND_HID     = 2'd0,
		KIND_WEBUSB  = 2'd1,
		KIND_BATTERY = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]  hid_code;
		logic [7:0]  webusb_code;
		logic [7:0]  battery_code;
		logic [15:0] low_level_limit;
		logic        battery_check_enable;
	} cfg_t;

	typedef struct packed {
		ev_t        event_res;
		kind_t      command_kind;
		logic [5:0] byte_index;
		logic [7:0] data_byte;
		logic       frame_last;
		logic       battery_low;
		logic       battery_low_first;
	} res_t;

endpackage

FILE: rtl/cufp_cfg_regs.sv
module cufp_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [cufp_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [cufp_pkg::CFG_DATA_W-1:0]    wr_data,
	output cufp_pkg::cfg_t                     cfg
);

	cufp_pkg::cfg_t cfg_q;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hid_code              <= 8'd1;
			cfg_q.webusb_code           <= 8'd2;
			cfg_q.battery_code          <= 8'd3;
			cfg_q.low_level_limit       <= 16'd3100;
			cfg_q.battery_check_enable  <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				cufp_pkg::CFG_HID_CODE:     cfg_q.hid_code <= wr_data[7:0];
				cufp_pkg::CFG_WEBUSB_CODE:  cfg_q.webusb_code <= wr_data[7:0];
				cufp_pkg::CFG_BATTERY_CODE: cfg_q.battery_code <= wr_data[7:0];
				cufp_pkg::CFG_LOW_THRESH:   cfg_q.low_level_limit <= wr_data;
				cufp_pkg::CFG_CHECK_EN:     cfg_q.battery_check_enable <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/cufp_parse.sv
module cufp_parse #(
	parameter int HID_PAYLOAD_BYTES    = cufp_pkg::HID_PAYLOAD_BYTES_DEF,
	parameter int WEBUSB_PAYLOAD_BYTES = cufp_pkg::WEBUSB_PAYLOAD_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     rx_byte,
	input  cufp_pkg::cfg_t cfg,
	output logic           has_result,
	output cufp_pkg::res_t res
);

	localparam logic [6:0] HID_LEN     = 7'(HID_PAYLOAD_BYTES);
	localparam logic [6:0] WEBUSB_LEN  = 7'(WEBUSB_PAYLOAD_BYTES);
	localparam logic [6:0] BATTERY_LEN = 7'(cufp_pkg::BATTERY_PAYLOAD_BYTES);

	logic [6:0]              pos_q, pos_nxt;
	cufp_pkg::kind_t         cmd_q, cmd_nxt;
	logic [31:0]             acc_q, acc_nxt;
	logic                    seen_q, seen_nxt;
	logic                    sync_ok;
	logic [6:0]              pos_rel;
	logic [5:0]              idx;
	logic [6:0]              len;
	logic                    last;
	logic [31:0]             acc_or;
	logic                    low;

	// next state and result for the byte in the input register
	always_comb begin
		pos_nxt    = pos_q;
		cmd_nxt    = cmd_q;
		acc_nxt    = acc_q;
		seen_nxt   = seen_q;
		has_result = 1'b0;
		res        = '0;
		sync_ok    = (pos_q == cufp_pkg::POS_SYNC_A && rx_byte == cufp_pkg::SYNC_A) ||
			(pos_q == cufp_pkg::POS_SYNC_B && rx_byte == cufp_pkg::SYNC_B) ||
			(pos_q == cufp_pkg::POS_SYNC_C && rx_byte == cufp_pkg::SYNC_C);
		pos_rel    = pos_q - cufp_pkg::POS_PAYLOAD;
		idx        = pos_rel[5:0];

		// payload length of the open frame
		unique case (cmd_q)
			cufp_pkg::KIND_WEBUSB:  len = WEBUSB_LEN;
			cufp_pkg::KIND_BATTERY: len = BATTERY_LEN;
			default:                len = HID_LEN;
		endcase
		last = ({1'b0, idx} + 7'd1) >= len;

		// little-endian level assembly
		acc_or = acc_q;
		unique case (idx[1:0])
			2'd0: acc_or[7:0]   = acc_q[7:0]   | rx_byte;
			2'd1: acc_or[15:8]  = acc_q[15:8]  | rx_byte;
			2'd2: acc_or[23:16] = acc_q[23:16] | rx_byte;
			default: acc_or[31:24] = acc_q[31:24] | rx_byte;
		endcase
		low = last && cfg.battery_check_enable &&
			(acc_or < {16'd0, cfg.low_level_limit});

		if (pos_q < cufp_pkg::POS_COMMAND) begin
			// sync hunt, a breaking byte goes out as log
			if (sync_ok) begin
				pos_nxt = pos_q + 7'd1;
			end else begin
				pos_nxt       = cufp_pkg::POS_SYNC_A;
				has_result    = 1'b1;
				res.event_res = cufp_pkg::EV_LOG;
				res.data_byte = rx_byte;
			end
		end else if (pos_q == cufp_pkg::POS_COMMAND) begin
			// command decode, earlier codes win on overlap
			pos_nxt = cufp_pkg::POS_PAYLOAD;
			acc_nxt = '0;
			priority if (rx_byte == cfg.hid_code) begin
				cmd_nxt = cufp_pkg::KIND_HID;
			end else if (rx_byte == cfg.webusb_code) begin
				cmd_nxt = cufp_pkg::KIND_WEBUSB;
			end else if (rx_byte == cfg.battery_code) begin
				cmd_nxt = cufp_pkg::KIND_BATTERY;
			end else begin
				pos_nxt       = cufp_pkg::POS_SYNC_A;
				cmd_nxt       = cufp_pkg::KIND_HID;
				acc_nxt       = acc_q;
				has_result    = 1'b1;
				res.event_res = cufp_pkg::EV_UNKNOWN;
				res.data_byte = rx_byte;
			end
		end else begin
			// payload byte
			has_result       = 1'b1;
			res.event_res    = cufp_pkg::EV_PAYLOAD;
			res.command_kind = cmd_q;
			res.byte_index   = idx;
			res.data_byte    = rx_byte;
			res.frame_last   = last;
			if (cmd_q == cufp_pkg::KIND_BATTERY) begin
				acc_nxt         = acc_or;
				res.battery_low = low;
				if (low && !seen_q) begin
					res.battery_low_first = 1'b1;
					seen_nxt              = 1'b1;
				end
			end
			if (last) begin
				pos_nxt = cufp_pkg::POS_SYNC_A;
				cmd_nxt = cufp_pkg::KIND_HID;
			end else begin
				pos_nxt = pos_q + 7'd1;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= cufp_pkg::POS_SYNC_A;
			cmd_q  <= cufp_pkg::KIND_HID;
			acc_q  <= '0;
			seen_q <= 1'b0;
		end else if (step) begin
			pos_q  <= pos_nxt;
			cmd_q  <= cmd_nxt;
			acc_q  <= acc_nxt;
			seen_q <= seen_nxt;
		end
	end

endmodule

FILE: rtl/uart_command_frame_parser_unit.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------------------
// in       | sink      | in_valid / in_ready    | rx_byte
// out      | source    | out_valid / out_ready  | event_res, command_kind, byte_index,
//          |           |                        | data_byte, frame_last, battery_low,
//          |           |                        | battery_low_first
// cfg      | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one byte per cycle while out is not stalled: a byte is held in the input register, then its result
// lands in the output register; matching sync bytes and known command codes give no result
// a stall on out holds the input register, and in_ready drops only when both are full
// cfg_ready is always high; reset starts the sync hunt with the default codes
module uart_command_frame_parser_unit #(
	parameter int HID_PAYLOAD_BYTES    = cufp_pkg::HID_PAYLOAD_BYTES_DEF,
	parameter int WEBUSB_PAYLOAD_BYTES = cufp_pkg::WEBUSB_PAYLOAD_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      event_res,
	output logic [1:0]                      command_kind,
	output logic [5:0]                      byte_index,
	output logic [7:0]                      data_byte,
	output logic                            frame_last,
	output logic                            battery_low,
	output logic                            battery_low_first,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cufp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cufp_pkg::CFG_DATA_W-1:0] cfg_data
);

	cufp_pkg::cfg_t cfg;
	cufp_pkg::res_t res, res_q;
	logic           vld_s1;
	logic [7:0]     byte_s1;
	logic           out_valid_q;
	logic           advance;
	logic           has_result;

	// configuration port
	assign cfg_ready = 1'b1;

	cufp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the input register moves on when the output slot is free or being emptied
	assign advance  = vld_s1 && (!out_valid_q || out_ready);
	assign in_ready = !vld_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	cufp_parse #(
		.HID_PAYLOAD_BYTES    (HID_PAYLOAD_BYTES),
		.WEBUSB_PAYLOAD_BYTES (WEBUSB_PAYLOAD_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (byte_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.res        (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign event_res         = res_q.event_res;
	assign command_kind      = res_q.command_kind;
	assign byte_index        = res_q.byte_index;
	assign data_byte         = res_q.data_byte;
	assign frame_last        = res_q.frame_last;
	assign battery_low       = res_q.battery_low;
	assign battery_low_first = res_q.battery_low_first;

endmodule
